// ===== sv/tcld_pkg.sv =====
`default_nettype none
package tcld_pkg;

   // Character codes seen on the byte channel.
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
   localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI = 8'h7f;
   localparam logic [7:0] CHAR_COMMA    = 8'h2c;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   // Scanning of numbers starts at this character position.
   localparam int SCAN_START = 5;

   // Keywords, left-justified in 64 bits, first character in the top byte.
   localparam int KW_COUNT = 5;
   localparam logic [63:0] KW_FLASH    = {"flash", 24'h0};
   localparam logic [63:0] KW_SOUNDOFF = "soundoff";
   localparam logic [63:0] KW_SOUND    = {"sound", 24'h0};
   localparam logic [63:0] KW_COLOR    = {"color", 24'h0};
   localparam logic [63:0] KW_RESET    = {"reset", 24'h0};
   // Keywords that are eight characters long; all others are five.
   localparam logic [KW_COUNT-1:0] KW_LONG_MASK = 5'b00010;

   // Color slots and the comma counter.
   localparam int SLOT_COUNT = 6;
   localparam int HALF_SLOTS = 3;
   localparam int COMMA_W    = 3;

   // Decoupling queue between the front and the back; depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_DEFAULT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOUND_DEFAULT = 4'd1;
   localparam logic [15:0] FLASH_DEFAULT_RESET = 16'd200;
   localparam logic [15:0] SOUND_DEFAULT_RESET = 16'd10;

   // Saturation limits.
   localparam logic [19:0] DURATION_MAX = 20'd65535;
   localparam logic [11:0] COLOR_MAX    = 12'd255;

   typedef enum logic [2:0] {
      CMD_FLASH    = 3'd0,
      CMD_SOUNDOFF = 3'd1,
      CMD_SOUND    = 3'd2,
      CMD_COLOR    = 3'd3,
      CMD_RESET    = 3'd4,
      CMD_UNKNOWN  = 3'd5
   } tcld_cmd_type;

   // One classified word from the front to the back.
   typedef struct packed {
      logic       is_eol;
      logic [7:0] char_code;
      logic [2:0] kw_pos;
      logic       in_prefix;
      logic       scan;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_comma;
      logic       len_ge5;
      logic       len_ge8;
      logic [5:0] line_length;
   } tcld_token_type;

   typedef struct packed {
      logic [15:0] flash_default;
      logic [15:0] sound_default;
   } tcld_cfg_type;

   typedef struct packed {
      tcld_cmd_type                  kind;
      logic [15:0]                   duration;
      logic [SLOT_COUNT-1:0][7:0]    color;
      logic [5:0]                    line_length;
   } tcld_result_type;

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
      logic [63:0] w;
      case (k)
         3'd0:    w = KW_FLASH;
         3'd1:    w = KW_SOUNDOFF;
         3'd2:    w = KW_SOUND;
         3'd3:    w = KW_COLOR;
         3'd4:    w = KW_RESET;
         default: w = 64'h0;
      endcase
      return w[{3'd7 - pos, 3'b000} +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== sv/text_command_line_decoder.sv =====
// Text command line decoder.
//
// The req_ channel carries one received byte per word. Printable bytes are
// collected into a line of up to LINE_CAPACITY characters; a newline byte
// closes the line and produces exactly one decoded command on the rsp_
// channel. Every other byte produces nothing on the rsp_ channel.
// The csr_ channel writes the flash and sound default durations; csr_ready
// is always high. Write it only while no line is being decoded.
//
// A newline accepted on req_ is first written into the decoupling queue and,
// when the back end takes it from the head of the queue, into the output
// register that drives its command on rsp_.
// Throughput: one byte per cycle, sustained indefinitely while rsp_ready is
// high; this rate is set by the single-byte update of the back-end scanner.
// When the receiver stalls, the finished command waits in the output register
// and bytes keep flowing until the next newline reaches the head of the queue.
// That newline waits there, one more kept byte fills the queue behind it, and
// then req_ready drops. After reset the line is empty, all keyword matches are
// armed, and the defaults are 200 (flash) and 10 (sound).
`default_nettype none
module text_command_line_decoder #(
   parameter int LINE_CAPACITY = 32,
   parameter int COLOR_COUNT   = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_in_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_command_kind,
   output logic [15:0]                          rsp_duration_value,
   output logic [7:0]                           rsp_color_first,
   output logic [7:0]                           rsp_color_second,
   output logic [7:0]                           rsp_color_third,
   output logic [7:0]                           rsp_color_fourth,
   output logic [7:0]                           rsp_color_fifth,
   output logic [7:0]                           rsp_color_sixth,
   output logic [5:0]                           rsp_line_length,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tcld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]                     csr_wdata
);
   import tcld_pkg::*;

   // Configuration registers. Writes to an index outside the register list
   // complete the handshake but change nothing.
   tcld_cfg_type cfg_ff, cfg_in;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FLASH_DEFAULT) begin
            cfg_in.flash_default = csr_wdata;
         end else if (csr_index == CSR_SOUND_DEFAULT) begin
            cfg_in.sound_default = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_default <= FLASH_DEFAULT_RESET;
         cfg_ff.sound_default <= SOUND_DEFAULT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each byte, tracks the line position and drops
   // bytes that are not kept, so only useful words enter the queue.
   logic           q_full, q_push, q_valid, q_pop;
   tcld_token_type q_push_tok, q_tok;

   tcld_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .queue_full  (q_full),
      .push        (q_push),
      .push_tok    (q_push_tok)
   );

   tcld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_tok  (q_push_tok),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_tok   (q_tok)
   );

   // The back end matches keywords, accumulates the duration and the color
   // values, and loads the output register when a line closes. It holds a
   // newline word in the queue only while the output register is still full.
   tcld_result_type res;

   tcld_back #(
      .COLOR_COUNT(COLOR_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok       (q_tok),
      .tok_take  (q_pop),
      .cfg       (cfg_ff),
      .res_valid (rsp_valid),
      .res_ready (rsp_ready),
      .res       (res)
   );

   always_comb begin
      rsp_command_kind   = res.kind;
      rsp_duration_value = res.duration;
      rsp_color_first    = res.color[0];
      rsp_color_second   = res.color[1];
      rsp_color_third    = res.color[2];
      rsp_color_fourth   = res.color[3];
      rsp_color_fifth    = res.color[4];
      rsp_color_sixth    = res.color[5];
      rsp_line_length    = res.line_length;
   end

   // A command other than flash or sound never carries a duration.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind != CMD_FLASH && rsp_command_kind != CMD_SOUND
      |-> rsp_duration_value == 16'd0)
      else $error("duration reported for a command without one");

   // Only a color command carries color values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind != CMD_COLOR
      |-> (rsp_color_first | rsp_color_second | rsp_color_third |
           rsp_color_fourth | rsp_color_fifth | rsp_color_sixth) == 8'd0)
      else $error("color values reported for a non-color command");

   // The reported line length never exceeds the line capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (LINE_CAPACITY < 64) |-> rsp_line_length <= 6'(LINE_CAPACITY))
      else $error("line length beyond capacity");

endmodule
`default_nettype wire

// ===== sv/tcld_front.sv =====
`default_nettype none
module tcld_front #(
   parameter int LINE_CAPACITY = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_in_char,
   input  wire logic                    queue_full,
   output logic                         push,
   output tcld_pkg::tcld_token_type     push_tok
);
   import tcld_pkg::*;

   localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic accept, is_nl, printable, room;

   always_comb begin
      req_ready = !queue_full;
      accept    = req_valid && req_ready;
      is_nl     = req_in_char == CHAR_NEWLINE;
      printable = req_in_char >= CHAR_PRINT_LO && req_in_char <= CHAR_PRINT_HI;
      room      = count_ff < CNT_W'(LINE_CAPACITY);
      push      = accept && (is_nl || (printable && room));

      push_tok.is_eol      = is_nl;
      push_tok.char_code   = req_in_char;
      push_tok.kw_pos      = count_ff[2:0];
      push_tok.in_prefix   = count_ff < CNT_W'(8);
      push_tok.scan        = count_ff >= CNT_W'(SCAN_START);
      push_tok.is_digit    = req_in_char >= CHAR_ZERO && req_in_char <= CHAR_NINE;
      push_tok.digit       = 4'(req_in_char - CHAR_ZERO);
      push_tok.is_comma    = req_in_char == CHAR_COMMA;
      push_tok.len_ge5     = count_ff >= CNT_W'(5);
      push_tok.len_ge8     = count_ff >= CNT_W'(8);
      push_tok.line_length = 6'(count_ff);

      count_in = count_ff;
      if (accept) begin
         if (is_nl) begin
            count_in = '0;
         end else if (printable && room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tcld_queue.sv =====
`default_nettype none
module tcld_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire tcld_pkg::tcld_token_type push_tok,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         pop_valid,
   output tcld_pkg::tcld_token_type     pop_tok
);
   import tcld_pkg::*;

   tcld_token_type tok_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full      = count_ff == QCNT_W'(QUEUE_DEPTH);
      pop_valid = count_ff != '0;
      pop_tok   = tok_ff[rd_ff];
      do_push   = push && !full;
      do_pop    = pop && pop_valid;
      wr_in     = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in     = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         tok_ff[wr_ff] <= push_tok;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tcld_back.sv =====
`default_nettype none
module tcld_back #(
   parameter int COLOR_COUNT = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tok_valid,
   input  wire tcld_pkg::tcld_token_type tok,
   output logic                          tok_take,
   input  wire tcld_pkg::tcld_cfg_type   cfg,
   output logic                          res_valid,
   input  wire logic                     res_ready,
   output tcld_pkg::tcld_result_type     res
);
   import tcld_pkg::*;

   logic [KW_COUNT-1:0]   flags_ff, flags_in;
   logic [15:0]           num_ff, num_in;
   logic [7:0]            color_ff [SLOT_COUNT];
   logic [7:0]            color_in [SLOT_COUNT];
   logic [COMMA_W-1:0]    comma_ff, comma_in;
   logic                  stopped_ff, stopped_in;
   logic                  res_valid_ff, res_valid_in;
   tcld_result_type       res_ff, res_in;

   logic out_free, keep_take, eol_take, in_prefix_k;
   logic [19:0] num_ext, num_next;
   logic [11:0] col_ext, col_next;
   logic [7:0]  cur_color;
   logic [7:0]  col_sat;
   logic [15:0] num_sat;
   logic [KW_COUNT-1:0] hit;
   tcld_cmd_type kind;

   always_comb begin
      out_free  = !res_valid_ff || res_ready;
      tok_take  = tok_valid && (!tok.is_eol || out_free);
      keep_take = tok_take && !tok.is_eol;
      eol_take  = tok_take && tok.is_eol;

      // Color slot addressed by the comma counter.
      cur_color = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (comma_ff == COMMA_W'(s)) begin
            cur_color = color_ff[s];
         end
      end

      // Multiply by ten as two shifts and an add, add the digit, then saturate.
      num_ext  = {4'b0, num_ff};
      num_next = (num_ext << 3) + (num_ext << 1) + 20'(tok.digit);
      num_sat  = num_next > DURATION_MAX ? 16'hffff : num_next[15:0];
      col_ext  = {4'b0, cur_color};
      col_next = (col_ext << 3) + (col_ext << 1) + 12'(tok.digit);
      col_sat  = col_next > COLOR_MAX ? 8'hff : col_next[7:0];

      flags_in    = flags_ff;
      num_in      = num_ff;
      comma_in    = comma_ff;
      stopped_in  = stopped_ff;
      in_prefix_k = 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         color_in[s] = color_ff[s];
      end

      if (keep_take) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            in_prefix_k = KW_LONG_MASK[k] ? tok.in_prefix : !tok.scan;
            if (in_prefix_k && tok.char_code != kw_char(3'(k), tok.kw_pos)) begin
               flags_in[k] = 1'b0;
            end
         end
         if (tok.scan) begin
            if (tok.is_digit) begin
               num_in = num_sat;
               if (!stopped_ff && comma_ff < COMMA_W'(COLOR_COUNT)) begin
                  for (int s = 0; s < SLOT_COUNT; s++) begin
                     if (comma_ff == COMMA_W'(s)) begin
                        color_in[s] = col_sat;
                     end
                  end
               end
            end else if (tok.is_comma && !stopped_ff) begin
               comma_in = comma_ff + COMMA_W'(1);
               if (comma_in >= COMMA_W'(COLOR_COUNT)) begin
                  stopped_in = 1'b1;
               end
            end
         end
      end else if (eol_take) begin
         flags_in   = '1;
         num_in     = '0;
         comma_in   = '0;
         stopped_in = 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            color_in[s] = '0;
         end
      end

      // Keyword choice in priority order.
      for (int k = 0; k < KW_COUNT; k++) begin
         hit[k] = flags_ff[k] && (KW_LONG_MASK[k] ? tok.len_ge8 : tok.len_ge5);
      end
      if (hit[0]) begin
         kind = CMD_FLASH;
      end else if (hit[1]) begin
         kind = CMD_SOUNDOFF;
      end else if (hit[2]) begin
         kind = CMD_SOUND;
      end else if (hit[3]) begin
         kind = CMD_COLOR;
      end else if (hit[4]) begin
         kind = CMD_RESET;
      end else begin
         kind = CMD_UNKNOWN;
      end

      res_in.kind        = kind;
      res_in.line_length = tok.line_length;
      case (kind)
         CMD_FLASH: res_in.duration = num_ff != '0 ? num_ff : cfg.flash_default;
         CMD_SOUND: res_in.duration = num_ff != '0 ? num_ff : cfg.sound_default;
         default:   res_in.duration = '0;
      endcase
      for (int s = 0; s < SLOT_COUNT; s++) begin
         res_in.color[s] = '0;
         if (kind == CMD_COLOR) begin
            if (s >= HALF_SLOTS && comma_ff < COMMA_W'(HALF_SLOTS)) begin
               res_in.color[s] = color_ff[(s >= HALF_SLOTS) ? s - HALF_SLOTS : s];
            end else begin
               res_in.color[s] = color_ff[s];
            end
         end
      end

      if (eol_take) begin
         res_valid_in = 1'b1;
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end

      res_valid = res_valid_ff;
      res       = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '1;
         num_ff       <= '0;
         comma_ff     <= '0;
         stopped_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            color_ff[s] <= '0;
         end
      end else begin
         flags_ff     <= flags_in;
         num_ff       <= num_in;
         comma_ff     <= comma_in;
         stopped_ff   <= stopped_in;
         res_valid_ff <= res_valid_in;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            color_ff[s] <= color_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eol_take) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire
